// File: rtl/i2c_slave_byte_engine_macros.svh
// Assertion macros shared by the I2C slave byte engine RTL.
// Depends on nothing; files that assert include it by name.
`ifndef I2C_SLAVE_BYTE_ENGINE_MACROS_SVH
`define I2C_SLAVE_BYTE_ENGINE_MACROS_SVH

// Implication checked on every rising clk edge outside reset
`define I2CSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, but also checked while reset is held
`define I2CSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/i2cse_pkg.sv
// Types and fixed codes for the I2C slave byte engine.
// Depends on nothing; used by i2c_slave_byte_engine.
package i2cse_pkg;

  // Event codes on in_op
  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_SHIFT    = 3'd1;
  localparam logic [2:0] OP_HOST_WR  = 3'd2;
  localparam logic [2:0] OP_HOST_RD  = 3'd3;
  localparam logic [2:0] OP_ARM      = 3'd4;

  // Transfer mode register values
  localparam logic [1:0] MODE_WAIT   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_ADDR = 2'd0;
  localparam logic [1:0] CFG_IDX_MODE = 2'd1;

  // Edge counter presets
  localparam logic [3:0] PRESET_START = 4'd0;
  localparam logic [3:0] PRESET_ACK   = 4'd14;
  localparam logic [3:0] PRESET_BYTE  = 4'd1;
  localparam logic [3:0] PRESET_RACK  = 4'd15;

  // Phase codes reported on out_phase
  localparam logic [2:0] PHC_IDLE     = 3'd0;
  localparam logic [2:0] PHC_ADDR     = 3'd1;
  localparam logic [2:0] PHC_SEND     = 3'd2;
  localparam logic [2:0] PHC_SEND_ACK = 3'd3;
  localparam logic [2:0] PHC_SEND_FIN = 3'd4;
  localparam logic [2:0] PHC_RECV     = 3'd5;
  localparam logic [2:0] PHC_RECV_ACK = 3'd6;

  // Bus phase machine, one-hot
  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_ADDR     = 7'b0000010,
    PH_SEND     = 7'b0000100,
    PH_SEND_ACK = 7'b0001000,
    PH_SEND_FIN = 7'b0010000,
    PH_RECV     = 7'b0100000,
    PH_RECV_ACK = 7'b1000000
  } phase_t;

  // One result beat
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       sda_drive;
    logic [3:0] count_preset;
    logic       overflow_enable;
    logic       bus_released;
    logic       transfer_done;
    logic [7:0] read_data;
    logic [2:0] phase;
  } result_t;

  // Result beat waiting on the buffer read data
  typedef struct packed {
    result_t res;
    logic    tx_from_buf;
    logic    rd_from_buf;
  } stage_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    code = PHC_IDLE;
    unique case (ph)
      PH_IDLE:     code = PHC_IDLE;
      PH_ADDR:     code = PHC_ADDR;
      PH_SEND:     code = PHC_SEND;
      PH_SEND_ACK: code = PHC_SEND_ACK;
      PH_SEND_FIN: code = PHC_SEND_FIN;
      PH_RECV:     code = PHC_RECV;
      PH_RECV_ACK: code = PHC_RECV_ACK;
      default:     code = PHC_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/i2c_slave_byte_engine.sv
// Top level of the I2C slave byte engine: phase machine, packet buffer, output stages.
// Depends on i2cse_pkg and i2c_slave_byte_engine_macros.svh.
//
// Takes one bus or host event per clock while in_stall is low and returns exactly
// one result beat per event: the event updates the phase machine and
// addresses the packet buffer in the accepting cycle, the buffer's registered
// read port delivers its byte into the event stage, and the output register
// then presents the beat. Because the event stage and the output register are
// separate, an event is still taken while a result waits on out_stall; in_stall
// rises only when both stages are full and the output is stalled. The buffer
// comes out of reset reading all zeros through per-entry valid bits, so there
// is no clearing pass. cfg_ready is always high.
module i2c_slave_byte_engine #(
  parameter int PACKET_BYTES = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  // event channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [7:0] in_bus_byte,
  input  logic [3:0] in_host_index,
  input  logic [7:0] in_host_data,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_sda_drive,
  output logic [3:0] out_count_preset,
  output logic       out_overflow_enable,
  output logic       out_bus_released,
  output logic       out_transfer_done,
  output logic [7:0] out_read_data,
  output logic [2:0] out_phase,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import i2cse_pkg::*;

`include "i2c_slave_byte_engine_macros.svh"

  localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam logic [4:0] CNT_FULL = 5'(PACKET_BYTES);
  localparam logic [4:0] CNT_MAX  = 5'd31;

  // Architectural state
  phase_t      phase_r, phase_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        sda_r, sda_nxt;
  logic [7:0]  addr_r;
  logic [1:0]  mode_r;

  // Packet buffer
  logic [7:0]              buf_mem [PACKET_BYTES];
  logic [PACKET_BYTES-1:0] buf_vld_r;
  logic [7:0]              buf_q_r;
  logic                    buf_q_vld_r;
  logic                    buf_we, buf_re;
  logic [AW-1:0]           buf_addr;
  logic [7:0]              buf_wdata;

  // Pipeline stages
  stage_t  s1_r, s1_nxt;
  logic    s1_v_r;
  result_t o_r, o_nxt;
  logic    o_v_r;
  logic    in_acc, s1_adv;

  // Event decode scratch
  logic [4:0] cnt_inc, cnt_snd;
  logic       rel, tx_from_buf, rd_from_buf;
  logic [3:0] preset;
  logic       host_ok, full_cur, full_snd, full_nxt;
  logic [7:0] buf_byte;

  assign cfg_ready = 1'b1;

  // Stage handshakes
  assign s1_adv   = !o_v_r || !out_stall;
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign cnt_inc  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 5'd1;
  assign host_ok  = {1'b0, in_host_index} < CNT_FULL;
  assign full_cur = cnt_r >= CNT_FULL;
  assign full_snd = cnt_snd >= CNT_FULL;
  assign full_nxt = cnt_nxt >= CNT_FULL;

  // Decode one event
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    sda_nxt     = sda_r;
    cnt_snd     = cnt_r;
    rel         = 1'b0;
    preset      = PRESET_START;
    tx_from_buf = 1'b0;
    rd_from_buf = 1'b0;
    buf_we      = 1'b0;
    buf_re      = 1'b0;
    buf_addr    = in_host_index[AW-1:0];
    buf_wdata   = in_host_data;
    unique case (in_op)
      OP_START: begin
        cnt_nxt   = 5'd0;
        phase_nxt = PH_ADDR;
        sda_nxt   = 1'b0;
      end
      OP_SHIFT: begin
        unique case (phase_r) inside
          PH_ADDR: begin
            if ({1'b0, in_bus_byte[7:1]} != addr_r) begin
              rel = 1'b1;
            end else begin
              phase_nxt = in_bus_byte[0] ? PH_SEND : PH_RECV;
              sda_nxt   = (in_bus_byte[0] && mode_r == MODE_READ) ||
                          (!in_bus_byte[0] && mode_r == MODE_WRITE);
              preset    = PRESET_ACK;
            end
          end
          PH_RECV: begin
            phase_nxt = PH_RECV_ACK;
            sda_nxt   = 1'b0;
            preset    = PRESET_BYTE;
          end
          PH_RECV_ACK: begin
            if (full_cur) begin
              rel = 1'b1;
            end else begin
              phase_nxt = PH_RECV;
              buf_we    = 1'b1;
              buf_addr  = cnt_r[AW-1:0];
              buf_wdata = in_bus_byte;
              cnt_nxt   = cnt_inc;
              sda_nxt   = 1'b1;
              preset    = PRESET_RACK;
            end
          end
          PH_SEND, PH_SEND_FIN: begin
            // in the send-finish phase count the byte just sent, ACK or NACK, then drop on NACK or a spent buffer
            cnt_snd = (phase_r == PH_SEND_FIN) ? cnt_inc : cnt_r;
            cnt_nxt = cnt_snd;
            if (phase_r == PH_SEND_FIN && in_bus_byte[1:0] != 2'd0) begin
              rel = 1'b1;
            end else begin
              if (phase_r == PH_SEND_FIN) begin
                sda_nxt = 1'b1;
              end
              if (full_snd) begin
                rel = 1'b1;
              end else begin
                phase_nxt   = PH_SEND_ACK;
                buf_re      = 1'b1;
                buf_addr    = cnt_snd[AW-1:0];
                tx_from_buf = 1'b1;
                preset      = PRESET_BYTE;
              end
            end
          end
          PH_SEND_ACK: begin
            phase_nxt = PH_SEND_FIN;
            sda_nxt   = 1'b0;
            preset    = PRESET_ACK;
          end
          default: begin
          end
        endcase
        if (rel) begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          preset    = PRESET_START;
        end
      end
      OP_HOST_WR: begin
        buf_we = host_ok;
      end
      OP_HOST_RD: begin
        buf_re      = host_ok;
        rd_from_buf = host_ok;
      end
      OP_ARM: begin
        cnt_nxt   = 5'd0;
        phase_nxt = PH_IDLE;
      end
      default: begin
      end
    endcase
  end

  // Build the event-stage beat
  always_comb begin
    s1_nxt.res.tx_byte         = 8'd0;
    s1_nxt.res.sda_drive       = sda_nxt;
    s1_nxt.res.count_preset    = preset;
    s1_nxt.res.overflow_enable = phase_nxt != PH_IDLE;
    s1_nxt.res.bus_released    = rel;
    s1_nxt.res.transfer_done   = full_nxt;
    s1_nxt.res.read_data       = 8'd0;
    s1_nxt.res.phase           = phase_code(phase_nxt);
    s1_nxt.tx_from_buf         = tx_from_buf;
    s1_nxt.rd_from_buf         = rd_from_buf;
  end

  // Advance phase machine and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= CNT_FULL;
      sda_r   <= 1'b0;
      addr_r  <= 8'hff;
      mode_r  <= MODE_WAIT;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        sda_r   <= sda_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_IDX_ADDR: addr_r <= cfg_data;
          CFG_IDX_MODE: mode_r <= cfg_data[1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Buffer array: one access per event, registered read
  always_ff @(posedge clk) begin
    if (in_acc && buf_we) begin
      buf_mem[buf_addr] <= buf_wdata;
    end
    if (in_acc && buf_re) begin
      buf_q_r <= buf_mem[buf_addr];
    end
  end

  // Track written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r   <= '0;
      buf_q_vld_r <= 1'b0;
    end else if (in_acc) begin
      if (buf_we) begin
        buf_vld_r[buf_addr] <= 1'b1;
      end
      if (buf_re) begin
        buf_q_vld_r <= buf_vld_r[buf_addr];
      end
    end
  end

  assign buf_byte = buf_q_vld_r ? buf_q_r : 8'd0;

  // Event stage valid and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  // Output register: merge buffer byte, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (s1_adv) begin
      o_v_r <= s1_v_r;
    end
  end

  always_comb begin
    o_nxt           = s1_r.res;
    o_nxt.tx_byte   = s1_r.tx_from_buf ? buf_byte : 8'd0;
    o_nxt.read_data = s1_r.rd_from_buf ? buf_byte : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v_r) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid           = o_v_r;
  assign out_tx_byte         = o_r.tx_byte;
  assign out_sda_drive       = o_r.sda_drive;
  assign out_count_preset    = o_r.count_preset;
  assign out_overflow_enable = o_r.overflow_enable;
  assign out_bus_released    = o_r.bus_released;
  assign out_transfer_done   = o_r.transfer_done;
  assign out_read_data       = o_r.read_data;
  assign out_phase           = o_r.phase;

  // Checks
  `I2CSE_ASSERT(a_cnt_bound, cnt_r <= CNT_FULL, "byte count beyond packet size")
  `I2CSE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !s1_v_r && !o_v_r, "stage valid after reset")
  `I2CSE_ASSERT(a_acc_fills_s1, in_acc |=> s1_v_r, "accepted event missing from event stage")
  `I2CSE_ASSERT(a_rx_room, in_acc && buf_we && in_op == OP_SHIFT |-> !full_cur, "rx write on full")
  `I2CSE_ASSERT(a_release_idle,
                s1_v_r && s1_r.res.bus_released |->
                s1_r.res.phase == PHC_IDLE && !s1_r.res.sda_drive,
                "release left bus engaged")

endmodule

// File: dv/tb_i2c_slave_byte_engine.sv
// Self-checking testbench for the I2C slave byte engine: directed bus and host
// events, then randomized transfers, with a built-in predictor. Needs i2cse_pkg.
module tb_i2c_slave_byte_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cse_pkg::*;

  localparam int PACKET_BYTES = 5;
  localparam int CYCLE_LIMIT  = 500000;

  // Register index that decodes to nothing, and the mode that matches no direction
  localparam logic [1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [1:0] MODE_BAD      = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_op;
  logic [7:0] in_bus_byte;
  logic [3:0] in_host_index;
  logic [7:0] in_host_data;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_tx_byte;
  logic       out_sda_drive;
  logic [3:0] out_count_preset;
  logic       out_overflow_enable;
  logic       out_bus_released;
  logic       out_transfer_done;
  logic [7:0] out_read_data;
  logic [2:0] out_phase;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  // Predictor state
  logic [7:0] slave_addr_q;
  logic [1:0] mode_q;
  logic [2:0] phase_q;
  logic [4:0] byte_cnt;
  logic [7:0] pkt_buf [16];
  logic       sda_q;

  result_t     pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned events_sent;
  int unsigned cycle_count = 0;
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;

  i2c_slave_byte_engine #(.PACKET_BYTES(PACKET_BYTES)) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_bus_byte         (in_bus_byte),
    .in_host_index       (in_host_index),
    .in_host_data        (in_host_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_tx_byte         (out_tx_byte),
    .out_sda_drive       (out_sda_drive),
    .out_count_preset    (out_count_preset),
    .out_overflow_enable (out_overflow_enable),
    .out_bus_released    (out_bus_released),
    .out_transfer_done   (out_transfer_done),
    .out_read_data       (out_read_data),
    .out_phase           (out_phase),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_length();
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the engine model by one event and build the beat it should return
  task automatic predict_engine_result(input logic [2:0] op, input logic [7:0] bus,
                                       input logic [3:0] idx, input logic [7:0] data,
                                       output result_t res);
    logic [7:0] tx;
    logic [7:0] rd;
    logic [3:0] preset;
    logic       drop_bus;
    tx       = 8'h00;
    rd       = 8'h00;
    preset   = PRESET_START;
    drop_bus = 1'b0;
    case (op)
      OP_START: begin
        byte_cnt = 5'd0;
        phase_q  = PHC_ADDR;
        sda_q    = 1'b0;
      end
      OP_SHIFT: begin
        case (phase_q)
          PHC_ADDR: begin
            if ({1'b0, bus[7:1]} != slave_addr_q) begin
              drop_bus = 1'b1;
            end else begin
              phase_q = bus[0] ? PHC_SEND : PHC_RECV;
              // ACK only when the R/W bit agrees with the mode
              sda_q   = (bus[0] && mode_q == MODE_READ) || (!bus[0] && mode_q == MODE_WRITE);
              preset  = PRESET_ACK;
            end
          end
          PHC_RECV: begin
            phase_q = PHC_RECV_ACK;
            sda_q   = 1'b0;
            preset  = PRESET_BYTE;
          end
          PHC_RECV_ACK: begin
            if (byte_cnt >= PACKET_BYTES) begin
              drop_bus = 1'b1;
            end else begin
              phase_q = PHC_RECV;
              pkt_buf[byte_cnt[3:0]] = bus;
              if (byte_cnt < 5'd31) byte_cnt++;
              sda_q   = 1'b1;
              preset  = PRESET_RACK;
            end
          end
          PHC_SEND, PHC_SEND_FIN: begin
            // The count advances even when the master answers NACK
            if (phase_q == PHC_SEND_FIN) begin
              if (byte_cnt < 5'd31) byte_cnt++;
              if (bus[1:0] != 2'b00) drop_bus = 1'b1;
              else sda_q = 1'b1;
            end
            if (!drop_bus) begin
              if (byte_cnt >= PACKET_BYTES) begin
                drop_bus = 1'b1;
              end else begin
                phase_q = PHC_SEND_ACK;
                tx      = pkt_buf[byte_cnt[3:0]];
                preset  = PRESET_BYTE;
              end
            end
          end
          PHC_SEND_ACK: begin
            phase_q = PHC_SEND_FIN;
            sda_q   = 1'b0;
            preset  = PRESET_ACK;
          end
          default: ;
        endcase
        if (drop_bus) begin
          sda_q   = 1'b0;
          phase_q = PHC_IDLE;
          tx      = 8'h00;
          preset  = PRESET_START;
        end
      end
      OP_HOST_WR: begin
        if (idx < PACKET_BYTES) pkt_buf[idx] = data;
      end
      OP_HOST_RD: begin
        if (idx < PACKET_BYTES) rd = pkt_buf[idx];
      end
      OP_ARM: begin
        byte_cnt = 5'd0;
        phase_q  = PHC_IDLE;
      end
      default: ;
    endcase
    res.tx_byte         = tx;
    res.sda_drive       = sda_q;
    res.count_preset    = preset;
    res.overflow_enable = (phase_q != PHC_IDLE);
    res.bus_released    = drop_bus;
    res.transfer_done   = (byte_cnt >= PACKET_BYTES);
    res.read_data       = rd;
    res.phase           = phase_q;
  endtask

  // Offer one event beat after an optional gap; record its prediction on acceptance
  task automatic send_event(input logic [2:0] op, input logic [7:0] bus,
                            input logic [3:0] idx, input logic [7:0] data);
    int unsigned gap;
    result_t     res;
    gap = ($urandom_range(99) < in_gap_pct) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op         = op;
    in_bus_byte   = bus;
    in_host_index = idx;
    in_host_data  = data;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_engine_result(op, bus, idx, data, res);
    pending_results.push_back(res);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic shift_event(input logic [7:0] bus);
    send_event(OP_SHIFT, bus, 4'($urandom), 8'($urandom));
  endtask

  // Drop valid and wait until every expected beat is back
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register while the engine is idle
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    drain_results();
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IDX_ADDR: slave_addr_q = val;
      CFG_IDX_MODE: mode_q = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One bus transaction: start, address, then bytes in the chosen direction
  task automatic bus_transfer(input logic to_master, input int unsigned nbytes);
    logic [7:0] addr_byte;
    int unsigned i;
    addr_byte = ($urandom_range(99) < 85) ? {slave_addr_q[6:0], to_master} : 8'($urandom);
    send_event(OP_START, 8'($urandom), 4'($urandom), 8'($urandom));
    shift_event(addr_byte);
    for (i = 0; i < nbytes; i++) begin
      // Break off now and then with a new start or a host arm
      if ($urandom_range(99) < 4) begin
        send_event($urandom_range(1) ? OP_START : OP_ARM, 8'($urandom), 4'($urandom),
                   8'($urandom));
        return;
      end
      if (!to_master) begin
        shift_event(8'($urandom));
        shift_event(8'($urandom));
      end else begin
        shift_event(8'($urandom));
        shift_event(8'($urandom));
        if (i == nbytes - 1) shift_event({6'($urandom), 2'($urandom_range(1, 3))});
        else shift_event({6'($urandom), 2'b00});
      end
    end
  endtask

  function automatic logic [3:0] pick_index();
    if ($urandom_range(3) == 0) return 4'($urandom);
    return 4'($urandom_range(0, PACKET_BYTES - 1));
  endfunction

  // Compare one field of a result beat
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Host side and bus events with nothing addressed, at reset settings
  task automatic test_idle_and_host();
    in_gap_pct    = 30;
    out_stall_pct = 30;
    shift_event(8'hFF);
    send_event(OP_HOST_RD, 8'h00, 4'd0, 8'h00);
    send_event(OP_HOST_WR, 8'h00, 4'd0, 8'hFF);
    send_event(OP_HOST_WR, 8'hFF, 4'd4, 8'h00);
    send_event(OP_HOST_WR, 8'h00, 4'd15, 8'hA5);
    send_event(OP_HOST_RD, 8'h00, 4'd15, 8'h00);
    send_event(OP_HOST_RD, 8'h00, 4'd0, 8'h00);
    send_event(3'd7, 8'hFF, 4'd15, 8'hFF);
    send_event(OP_ARM, 8'h00, 4'd0, 8'h00);
    // Reset address never matches
    send_event(OP_START, 8'h00, 4'd0, 8'h00);
    shift_event(8'hFE);
  endtask

  // Master write of two bytes to the top address
  task automatic test_master_write();
    write_reg(CFG_IDX_ADDR, 8'h7F);
    write_reg(CFG_IDX_MODE, 8'(MODE_WRITE));
    send_event(OP_START, 8'h00, 4'd0, 8'h00);
    shift_event({7'h7F, 1'b0});
    shift_event(8'h00);
    shift_event(8'hFF);
    shift_event(8'hFF);
    shift_event(8'h00);
  endtask

  // Master read of one byte ending in NACK
  task automatic test_master_read();
    write_reg(CFG_IDX_MODE, 8'(MODE_READ));
    send_event(OP_START, 8'h00, 4'd0, 8'h00);
    shift_event({7'h7F, 1'b1});
    shift_event(8'h00);
    shift_event(8'h00);
    shift_event(8'h03);
  endtask

  // Mixed transfers, host accesses and noise under one register setting
  task automatic test_random_traffic(input logic [7:0] addr, input logic [1:0] mode,
                                     input int unsigned n_items, input int unsigned gap_pct,
                                     input int unsigned stall_pct);
    int unsigned target;
    int unsigned r;
    write_reg(CFG_IDX_ADDR, addr);
    write_reg(CFG_IDX_MODE, 8'(mode));
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    target = events_sent + n_items;
    while (events_sent < target) begin
      r = $urandom_range(99);
      if (r < 35) bus_transfer(1'b0, $urandom_range(0, 7));
      else if (r < 70) bus_transfer(1'b1, $urandom_range(1, 7));
      else if (r < 80) send_event(OP_HOST_WR, 8'($urandom), pick_index(), 8'($urandom));
      else if (r < 88) send_event(OP_HOST_RD, 8'($urandom), pick_index(), 8'($urandom));
      else if (r < 92) send_event(OP_ARM, 8'($urandom), 4'($urandom), 8'($urandom));
      else send_event(3'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
    end
  endtask

  // Random back-pressure on the result side
  initial begin : stall_driver
    int unsigned stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall = 1'b1;
      end else if ($urandom_range(99) < out_stall_pct) begin
        stall_left = idle_length() - 1;
        out_stall  = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Check each accepted result beat against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with nothing expected", $time);
      end else begin
        want = pending_results.pop_front();
        check_field("tx_byte", want.tx_byte, out_tx_byte);
        check_field("sda_drive", 8'(want.sda_drive), 8'(out_sda_drive));
        check_field("count_preset", 8'(want.count_preset), 8'(out_count_preset));
        check_field("overflow_enable", 8'(want.overflow_enable), 8'(out_overflow_enable));
        check_field("bus_released", 8'(want.bus_released), 8'(out_bus_released));
        check_field("transfer_done", 8'(want.transfer_done), 8'(out_transfer_done));
        check_field("read_data", want.read_data, out_read_data);
        check_field("phase", 8'(want.phase), 8'(out_phase));
      end
    end
  end

  // Watchdog on a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_i2c_slave_byte_engine: errors");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_START;
    in_bus_byte   = 8'h00;
    in_host_index = 4'd0;
    in_host_data  = 8'h00;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_IDX_ADDR;
    cfg_data      = 8'h00;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    events_sent   = 0;
    slave_addr_q  = 8'hFF;
    mode_q        = MODE_WAIT;
    phase_q       = PHC_IDLE;
    byte_cnt      = 5'(PACKET_BYTES);
    sda_q         = 1'b0;
    foreach (pkt_buf[i]) pkt_buf[i] = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_and_host();
    test_master_write();
    test_master_read();

    test_random_traffic(8'h00, MODE_WRITE, 100, 30, 30);
    test_random_traffic(8'h7F, MODE_READ, 100, 0, 0);
    test_random_traffic(8'($urandom_range(0, 127)), MODE_WAIT, 100, 50, 50);
    test_random_traffic(8'($urandom_range(0, 127)), MODE_BAD, 100, 20, 60);
    test_random_traffic(8'hFF, MODE_READ, 50, 30, 30);
    write_reg(CFG_IDX_SPARE, 8'($urandom));
    test_random_traffic(8'($urandom_range(128, 254)), 2'($urandom), 40, 30, 30);
    test_random_traffic(8'($urandom_range(0, 127)), 2'($urandom), 110, 40, 10);

    drain_results();
    if (mismatch_count == 0) begin
      $display("tb_i2c_slave_byte_engine: clean");
    end else begin
      $display("tb_i2c_slave_byte_engine: errors");
    end
    $finish;
  end

endmodule
